// File: sv/sraa_pkg.sv
// ----------------------------------------------------------------------------
// sraa_pkg: shared definitions for the single-region aligned allocator
// Address width, request codes and sequencer states.
// ----------------------------------------------------------------------------
package sraa_pkg;

    localparam int ADDR_BITS = 48;
    localparam int BIT_W     = $clog2(ADDR_BITS);
    localparam int CFG_IDX_W = 1;

    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_RESERVE = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_START = 1'b0,
        CFG_INITIAL_SIZE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ASLICE,
        ST_ACHECK,
        ST_AGRANT,
        ST_AMOVE,
        ST_SUM,
        ST_FAPPLY,
        ST_RCUT,
        ST_RAPPLY,
        ST_DONE
    } t_state;

endpackage

// File: sv/sraa_if.sv
// ----------------------------------------------------------------------------
// sraa_if: request and response channels of the allocator
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface sraa_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [sraa_pkg::ADDR_BITS-1:0] region_addr;
    logic [sraa_pkg::ADDR_BITS-1:0] length;
    logic [sraa_pkg::ADDR_BITS-1:0] alignment;

    modport source (output valid, req_type, region_addr, length, alignment, input ready);
    modport sink   (input valid, req_type, region_addr, length, alignment, output ready);
endinterface

interface sraa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [sraa_pkg::ADDR_BITS-1:0] alloc_addr;

    modport source (output valid, ok, alloc_addr, input ready);
    modport sink   (input valid, ok, alloc_addr, output ready);
endinterface

// File: sv/single_region_aligned_allocator_top.sv
// Allocate takes the start modulo the alignment bit-serially through one
//   shared subtract unit, then slices, checks the fit, grants, moves (on a
//   fit) and loads the response; free sums and applies; reserve sums, cuts
//   and applies; an unknown code answers directly. One transaction in flight;
//   the next is accepted the cycle after the response loads, later while a held response is not taken.
// Reset (synchronous, active low) clears the sequencer, the region and the response valid flag.
// ----------------------------------------------------------------------------
// single_region_aligned_allocator_top: one-region aligned bump allocator
// Tracks one free region (start, size). Allocate rounds the start up to any
// alignment, free merges adjacent chunks, reserve cuts out a range.
// ----------------------------------------------------------------------------
module single_region_aligned_allocator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sraa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sraa_pkg::ADDR_BITS-1:0]     i_cfg_wdata,
    sraa_req_if.sink                           i_req,
    sraa_rsp_if.source                         o_rsp
);

    localparam int AW = sraa_pkg::ADDR_BITS;

    // Sequencer
    sraa_pkg::t_state r_state, n_state;

    // Region state
    sraa_pkg::t_addr r_start, n_start;
    sraa_pkg::t_addr r_size,  n_size;

    // Captured request
    logic [1:0]      r_type,  n_type;
    sraa_pkg::t_addr r_addr,  n_addr;
    sraa_pkg::t_addr r_len,   n_len;
    sraa_pkg::t_addr r_align, n_align;

    // Shared remainder unit and scratch
    sraa_pkg::t_addr           r_rem,   n_rem;
    logic [sraa_pkg::BIT_W-1:0] r_bit,  n_bit;
    sraa_pkg::t_addr r_slice, n_slice;
    sraa_pkg::t_addr r_avail, n_avail;
    sraa_pkg::t_addr r_end,   n_end;
    sraa_pkg::t_addr r_cut,   n_cut;
    logic [AW:0]     r_sum,   n_sum;
    sraa_pkg::t_addr r_left,  n_left;
    sraa_pkg::t_addr r_right, n_right;
    logic            r_skip,  n_skip;
    logic            r_fit,   n_fit;

    // Result being built
    logic            r_res_ok,   n_res_ok;
    sraa_pkg::t_addr r_res_addr, n_res_addr;

    // Response register
    logic            r_out_valid;
    logic            r_out_ok;
    sraa_pkg::t_addr r_out_addr;

    logic            req_fire;
    logic            out_load;

    // Remainder step: shift in the next dividend bit, subtract if it fits
    logic [AW:0]     div_sh;
    logic            div_ge;
    logic [AW:0]     div_diff;

    // Allocation fit check
    logic [AW:0]     chk_diff;
    logic            chk_over;

    sraa_pkg::t_addr grown;

    assign req_fire = i_req.valid && i_req.ready;

    assign div_sh   = {r_rem, r_start[r_bit]};
    assign div_ge   = div_sh >= {1'b0, r_align};
    assign div_diff = div_sh - {1'b0, r_align};

    assign chk_diff = {1'b0, r_size} - {1'b0, r_slice};
    assign chk_over = chk_diff[AW] || (chk_diff[AW-1:0] == '0);

    assign grown = r_sum[AW] ? {AW{1'b1}} : r_sum[AW-1:0];

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sraa_pkg::ST_IDLE: begin
                if (req_fire) begin
                    if (i_req.req_type == sraa_pkg::REQ_ALLOC) begin
                        n_state = sraa_pkg::ST_DIV;
                    end else if (i_req.req_type == sraa_pkg::REQ_FREE ||
                                 i_req.req_type == sraa_pkg::REQ_RESERVE) begin
                        n_state = sraa_pkg::ST_SUM;
                    end else begin
                        n_state = sraa_pkg::ST_DONE;
                    end
                end
            end
            sraa_pkg::ST_DIV: begin
                if (r_bit == '0) begin
                    n_state = sraa_pkg::ST_ASLICE;
                end
            end
            sraa_pkg::ST_ASLICE: n_state = sraa_pkg::ST_ACHECK;
            sraa_pkg::ST_ACHECK: n_state = sraa_pkg::ST_AGRANT;
            sraa_pkg::ST_AGRANT: begin
                n_state = r_fit ? sraa_pkg::ST_AMOVE : sraa_pkg::ST_DONE;
            end
            sraa_pkg::ST_AMOVE: n_state = sraa_pkg::ST_DONE;
            sraa_pkg::ST_SUM: begin
                n_state = (r_type == sraa_pkg::REQ_FREE) ? sraa_pkg::ST_FAPPLY
                                                         : sraa_pkg::ST_RCUT;
            end
            sraa_pkg::ST_FAPPLY: n_state = sraa_pkg::ST_DONE;
            sraa_pkg::ST_RCUT:   n_state = sraa_pkg::ST_RAPPLY;
            sraa_pkg::ST_RAPPLY: n_state = sraa_pkg::ST_DONE;
            sraa_pkg::ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = sraa_pkg::ST_IDLE;
                end
            end
            default: n_state = sraa_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Output logic
    // ------------------------------------------------------------------
    always_comb begin
        i_req.ready = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            sraa_pkg::ST_IDLE: i_req.ready = 1'b1;
            sraa_pkg::ST_DONE: out_load    = !r_out_valid || o_rsp.ready;
            default: begin
                i_req.ready = 1'b0;
                out_load    = 1'b0;
            end
        endcase
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_out_ok;
    assign o_rsp.alloc_addr = r_out_addr;

    // ------------------------------------------------------------------
    // Datapath: each step uses one add/subtract group on the region
    // ------------------------------------------------------------------
    always_comb begin
        n_start    = r_start;
        n_size     = r_size;
        n_type     = r_type;
        n_addr     = r_addr;
        n_len      = r_len;
        n_align    = r_align;
        n_rem      = r_rem;
        n_bit      = r_bit;
        n_slice    = r_slice;
        n_avail    = r_avail;
        n_end      = r_end;
        n_cut      = r_cut;
        n_sum      = r_sum;
        n_left     = r_left;
        n_right    = r_right;
        n_skip     = r_skip;
        n_fit      = r_fit;
        n_res_ok   = r_res_ok;
        n_res_addr = r_res_addr;

        unique case (r_state)
            sraa_pkg::ST_IDLE: begin
                if (req_fire) begin
                    n_type     = i_req.req_type;
                    n_addr     = i_req.region_addr;
                    n_len      = i_req.length;
                    // zero alignment means no rounding
                    n_align    = (i_req.alignment == '0) ? AW'(1) : i_req.alignment;
                    n_rem      = '0;
                    n_bit      = sraa_pkg::BIT_W'(AW - 1);
                    n_res_ok   = 1'b0;
                    n_res_addr = '0;
                end
            end
            sraa_pkg::ST_DIV: begin
                n_rem = div_ge ? div_diff[AW-1:0] : div_sh[AW-1:0];
                n_bit = r_bit - 1'b1;
            end
            sraa_pkg::ST_ASLICE: begin
                n_slice = (r_rem != '0) ? (r_align - r_rem) : '0;
            end
            sraa_pkg::ST_ACHECK: begin
                n_avail  = chk_over ? '0 : chk_diff[AW-1:0];
                n_fit    = (r_len == '0) || (!chk_over && (chk_diff[AW-1:0] >= r_len));
                n_res_ok = n_fit;
            end
            sraa_pkg::ST_AGRANT: begin
                if (r_fit) begin
                    n_start = r_start + r_slice;
                    n_size  = r_avail - r_len;
                end
            end
            sraa_pkg::ST_AMOVE: begin
                n_res_addr = r_start;
                n_start    = r_start + r_len;
            end
            sraa_pkg::ST_SUM: begin
                n_end = r_start + r_size;
                n_cut = r_addr + r_len;
                n_sum = {1'b0, r_size} + {1'b0, r_len};
            end
            sraa_pkg::ST_FAPPLY: begin
                n_res_ok = 1'b1;
                // merge only a chunk that touches the region's end or start
                if (r_addr == r_end) begin
                    n_size = grown;
                end else if (r_cut == r_start) begin
                    n_size  = grown;
                    n_start = r_start - r_len;
                end
            end
            sraa_pkg::ST_RCUT: begin
                n_res_ok = 1'b1;
                n_skip   = (r_addr > r_end) || (r_cut <= r_start);
                n_left   = (r_addr > r_start) ? (r_addr - r_start) : '0;
                n_right  = (r_cut < r_end) ? (r_end - r_cut) : '0;
            end
            sraa_pkg::ST_RAPPLY: begin
                // keep the larger side of the region around the cut
                if (!r_skip) begin
                    if (r_left == '0 && r_right == '0) begin
                        n_size = '0;
                    end else if (r_left > r_right) begin
                        n_size = r_left;
                    end else begin
                        n_start = r_end - r_right;
                        n_size  = r_right;
                    end
                end
            end
            sraa_pkg::ST_DONE: begin
                n_res_ok = r_res_ok;
            end
            default: begin
                n_res_ok = r_res_ok;
            end
        endcase

        // configuration loads the region directly; the user must write it only while idle, the block does not check
        if (i_cfg_we) begin
            unique case (sraa_pkg::t_cfg_idx'(i_cfg_idx))
                sraa_pkg::CFG_INITIAL_START: n_start = i_cfg_wdata;
                sraa_pkg::CFG_INITIAL_SIZE:  n_size  = i_cfg_wdata;
                default:                     n_start = r_start;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sraa_pkg::ST_IDLE;
            r_start     <= '0;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_size  <= n_size;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type     <= n_type;
        r_addr     <= n_addr;
        r_len      <= n_len;
        r_align    <= n_align;
        r_rem      <= n_rem;
        r_bit      <= n_bit;
        r_slice    <= n_slice;
        r_avail    <= n_avail;
        r_end      <= n_end;
        r_cut      <= n_cut;
        r_sum      <= n_sum;
        r_left     <= n_left;
        r_right    <= n_right;
        r_skip     <= n_skip;
        r_fit      <= n_fit;
        r_res_ok   <= n_res_ok;
        r_res_addr <= n_res_addr;
        if (out_load) begin
            r_out_ok   <= r_res_ok;
            r_out_addr <= r_res_addr;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sraa_pkg::ST_DIV |-> r_align != '0)
        else $error("remainder unit running with zero divisor");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sraa_pkg::ST_DIV && r_bit == '0) |=> r_rem < r_align)
        else $error("remainder not below alignment");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> r_state != sraa_pkg::ST_IDLE)
        else $error("sequencer idle right after accepting a request");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> r_out_addr == '0)
        else $error("failed response carries a nonzero address");

endmodule

// File: sim/single_region_aligned_allocator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_region_aligned_allocator_top_test: allocator request/response check
// Drives allocate, free, reserve and unknown requests through the valid/ready
// channels under several region settings and idle mixes. Each response is
// checked against a cycle-free model of the region kept in a small tracker.
// ----------------------------------------------------------------------------
module single_region_aligned_allocator_top_test;
    import sraa_pkg::*;

    localparam t_addr       ADDR_MAX    = '1;
    localparam logic [1:0]  REQ_UNKNOWN = 2'd3;   // no operation behind this code
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned SEG_ITEMS   = 190;
    localparam int unsigned NUM_SEGS    = 8;

    typedef struct packed {
        logic [1:0] kind;
        t_addr      addr;
        t_addr      len;
        t_addr      align;
    } t_alloc_req;

    typedef struct packed {
        logic  ok;
        t_addr addr;
    } t_grant;

    // ------------------------------------------------------------------------
    // Region tracker: mirrors the free region and queues the grant that each
    // accepted request must produce.
    // ------------------------------------------------------------------------
    class region_tracker;
        t_addr       base;
        t_addr       span;
        t_grant      grants_due[$];
        int unsigned bad_responses;

        function new();
            base          = '0;
            span          = '0;
            bad_responses = 0;
        endfunction

        function void load(t_cfg_idx idx, t_addr value);
            if (idx == CFG_INITIAL_START) begin
                base = value;
            end else begin
                span = value;
            end
        endfunction

        function t_addr tail();
            return base + span;
        endfunction

        // Apply one request to the region and return its grant.
        function t_grant apply(t_alloc_req r);
            t_grant g;
            t_addr  align, rem, slice, top, grown, cut_end, left, right;
            g.ok   = 1'b0;
            g.addr = '0;
            top    = base + span;
            case (r.kind)
                REQ_ALLOC: begin
                    align = (r.align == '0) ? t_addr'(1) : r.align;
                    rem   = base % align;
                    slice = (rem != '0) ? align - rem : '0;
                    // zero length always fits; otherwise the padded slice
                    // must leave room for the whole request
                    if (r.len == '0 || (slice < span && span - slice >= r.len)) begin
                        span   = (slice >= span) ? '0 : span - slice;
                        base   = base + slice;
                        g.ok   = 1'b1;
                        g.addr = base;
                        span   = span - r.len;
                        base   = base + r.len;
                    end
                end
                REQ_FREE: begin
                    grown = (span > ADDR_MAX - r.len) ? ADDR_MAX : span + r.len;
                    if (r.addr == top) begin
                        span = grown;
                    end else if (t_addr'(r.addr + r.len) == base) begin
                        span = grown;
                        base = base - r.len;
                    end
                    g.ok = 1'b1;
                end
                REQ_RESERVE: begin
                    cut_end = r.addr + r.len;
                    if (!(r.addr > top || cut_end <= base)) begin
                        left  = (r.addr > base) ? r.addr - base : '0;
                        right = (cut_end < top) ? top - cut_end : '0;
                        if (left == '0 && right == '0) begin
                            span = '0;
                        end else if (left > right) begin
                            span = left;
                        end else begin
                            base = base + span - right;
                            span = right;
                        end
                    end
                    g.ok = 1'b1;
                end
                default: begin
                end
            endcase
            return g;
        endfunction

        function void note_request(t_alloc_req r);
            grants_due.push_back(apply(r));
        endfunction

        function void check_response(logic ok, t_addr addr);
            t_grant want;
            if (grants_due.size() == 0) begin
                bad_responses++;
                if (bad_responses <= 10)
                    $display("[%0t] response with nothing outstanding: ok=%b addr=%h",
                             $realtime, ok, addr);
                return;
            end
            want = grants_due.pop_front();
            if (ok !== want.ok || addr !== want.addr) begin
                bad_responses++;
                if (bad_responses <= 10)
                    $display("[%0t] response mismatch: expected ok=%b addr=%h, got ok=%b addr=%h",
                             $realtime, want.ok, want.addr, ok, addr);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    t_addr                i_cfg_wdata;

    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;
    int unsigned cycle_count   = 0;

    region_tracker tracker = new();

    sraa_req_if req_ch ();
    sraa_rsp_if rsp_ch ();

    single_region_aligned_allocator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop: far beyond the slowest legal run of every phase.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Response side: check each transaction, then pick ready for the next
    // edge. One ready update per edge keeps the handshake race free.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_response(rsp_ch.ok, rsp_ch.alloc_addr);
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Random value helpers
    // ------------------------------------------------------------------------
    function automatic t_addr rand48();
        logic [31:0] hi, lo;
        hi = $urandom;
        lo = $urandom;
        return {hi[15:0], lo};
    endfunction

    // Log-spread magnitude: small values are as likely as huge ones.
    function automatic t_addr rand_mag();
        logic [5:0] sh;
        if ($urandom_range(15) == 0)
            return '0;
        sh = 6'($urandom_range(47));
        return rand48() >> sh;
    endfunction

    function automatic t_addr rand_below(t_addr n);
        if (n == '0)
            return '0;
        return ($urandom_range(1) != 0) ? rand48() % n : rand_mag() % n;
    endfunction

    function automatic t_addr rand_align();
        t_addr one;
        one = 1;
        case ($urandom_range(19))
            0:             return t_addr'($urandom_range(1));    // zero or one
            1, 2:          return rand48();
            3, 4, 5, 6:    return t_addr'($urandom_range(1000, 1));
            default:       return one << $urandom_range(16);
        endcase
    endfunction

    // Mostly requests aimed at the current region (allocations that can fit,
    // chunks touching either end, cuts inside), some noise on top.
    function automatic t_alloc_req next_request();
        t_alloc_req  r;
        int unsigned pick;
        pick    = $urandom_range(99);
        r.kind  = REQ_ALLOC;
        r.addr  = rand48();
        r.len   = rand_mag();
        r.align = rand_align();
        if (pick < 40) begin
            if ($urandom_range(2) == 0)
                r.len = rand_below(tracker.span);
        end else if (pick < 58) begin
            r.kind = REQ_FREE;
            r.addr = tracker.tail();
        end else if (pick < 68) begin
            r.kind = REQ_FREE;
            r.addr = tracker.base - r.len;
        end else if (pick < 73) begin
            r.kind = REQ_FREE;
        end else if (pick < 90) begin
            r.kind = REQ_RESERVE;
            r.addr = tracker.base + rand_below(tracker.span);
        end else if (pick < 96) begin
            r.kind = REQ_RESERVE;
        end else begin
            r.kind = REQ_UNKNOWN;
        end
        return r;
    endfunction

    function automatic t_alloc_req mk(logic [1:0] kind, t_addr addr, t_addr len,
                                      t_addr align);
        t_alloc_req r;
        r.kind  = kind;
        r.addr  = addr;
        r.len   = len;
        r.align = align;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Present one request; hold valid high until the transaction is taken.
    task automatic send_request(input t_alloc_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.kind;
        req_ch.region_addr <= r.addr;
        req_ch.length      <= r.len;
        req_ch.alignment   <= r.align;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        tracker.note_request(r);
    endtask

    // Drop valid and wait until every queued grant has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (tracker.grants_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both region registers; only called while the block is idle.
    task automatic load_region(input t_addr start_val, input t_addr size_val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_INITIAL_START;
        i_cfg_wdata <= start_val;
        @(posedge i_clk);
        tracker.load(CFG_INITIAL_START, start_val);
        i_cfg_idx   <= CFG_INITIAL_SIZE;
        i_cfg_wdata <= size_val;
        @(posedge i_clk);
        tracker.load(CFG_INITIAL_SIZE, size_val);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_pressure(input int unsigned mode);
        case (mode)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 53; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 53; end
            default: begin send_idle_pct = 37; rsp_stall_pct = 37; end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_addr seg_base [NUM_SEGS];
        t_addr seg_size [NUM_SEGS];

        // Settings per phase: empty region, extremes, wrapping end, random.
        seg_base[0] = '0;                       seg_size[0] = '0;
        seg_base[1] = 48'h1000;                 seg_size[1] = 48'h10_0000;
        seg_base[2] = ADDR_MAX;                 seg_size[2] = ADDR_MAX;
        seg_base[3] = rand48() | 48'h1;         seg_size[3] = 48'h1_0000_0000;
        seg_base[4] = ADDR_MAX - 48'hFFF;       seg_size[4] = 48'h1_0000;
        seg_base[5] = rand48();                 seg_size[5] = rand48();
        seg_base[6] = '0;                       seg_size[6] = ADDR_MAX;
        seg_base[7] = 48'd12345;                seg_size[7] = 48'h10_0000;

        // Known values on every request input from time zero; the response
        // ready is owned by the response process.
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_INITIAL_START;
        i_cfg_wdata        <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_ALLOC;
        req_ch.region_addr <= '0;
        req_ch.length      <= '0;
        req_ch.alignment   <= 48'h1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: rounding, zero length, zero alignment, odd alignment,
        // oversize and over-aligned failures, cuts, adjacent frees.
        set_pressure(0);
        load_region(48'h1003, 48'h1_0000);
        send_request(mk(REQ_ALLOC, '0, 48'h10, 48'h10));
        send_request(mk(REQ_ALLOC, '0, '0, 48'h40));
        send_request(mk(REQ_ALLOC, '0, 48'h8, '0));
        send_request(mk(REQ_ALLOC, '0, 48'h7, 48'h3));
        send_request(mk(REQ_ALLOC, '0, ADDR_MAX, 48'h1));
        send_request(mk(REQ_ALLOC, '0, 48'h1, ADDR_MAX));
        send_request(mk(REQ_RESERVE, tracker.base + 48'h100, 48'h100, '0));
        send_request(mk(REQ_RESERVE, tracker.tail() + 48'h1, 48'h4, '0));
        send_request(mk(REQ_FREE, tracker.tail(), 48'h100, '0));
        send_request(mk(REQ_FREE, tracker.base - 48'h20, 48'h20, '0));
        send_request(mk(REQ_FREE, 48'hDEAD_0000_0000, 48'h10, '0));
        send_request(mk(REQ_RESERVE, tracker.base, tracker.span, '0));
        send_request(mk(REQ_ALLOC, '0, '0, 48'h1000));
        send_request(mk(REQ_ALLOC, '0, 48'h1, 48'h1));
        // growing past the top saturates the size
        send_request(mk(REQ_FREE, tracker.tail(), ADDR_MAX, '0));
        send_request(mk(REQ_UNKNOWN, ADDR_MAX, ADDR_MAX, ADDR_MAX));
        send_request(mk(REQ_UNKNOWN, '0, '0, '0));
        drain();

        // Region whose end wraps past the top of the address space.
        load_region(ADDR_MAX - 48'hF, 48'h20);
        send_request(mk(REQ_ALLOC, '0, 48'h10, 48'h20));
        send_request(mk(REQ_FREE, tracker.tail(), 48'h10, '0));
        send_request(mk(REQ_RESERVE, '0, 48'h8, '0));
        send_request(mk(REQ_ALLOC, '0, 48'h4, ADDR_MAX));
        send_request(mk(REQ_FREE, tracker.base - 48'h40, 48'h40, '0));
        send_request(mk(REQ_ALLOC, '0, '0, ADDR_MAX));
        drain();

        // Random phases: one setting each, idle mix rotating.
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            set_pressure(seg % 4);
            load_region(seg_base[seg], seg_size[seg]);
            repeat (SEG_ITEMS) send_request(next_request());
            drain();
        end

        // Let any stray response show up before the verdict.
        repeat (60) @(posedge i_clk);
        if (tracker.bad_responses == 0 && tracker.grants_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
